/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the literal recogniser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define NLR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define NLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/nlr_pkg.sv */
// ----------------------------------------------------------------------------
// nlr_pkg
// types, codes and character constants of the numeric literal recogniser
// ----------------------------------------------------------------------------
package nlr_pkg;

    localparam int MAX_DIGITS_DEF = 255;
    localparam int MAX_TEXT_DEF   = 255;
    localparam int MAX_SCAN_DEF   = 1023;

    localparam logic [5:0] BASE_MIN     = 6'd2;
    localparam logic [5:0] BASE_MAX     = 6'd36;
    localparam logic [5:0] BASE_DEFAULT = 6'd10;
    localparam logic [5:0] BASE_HEX     = 6'd16;
    localparam logic [5:0] BASE_OCT     = 6'd8;
    localparam logic [5:0] BASE_QUAT    = 6'd4;
    localparam logic [5:0] BASE_BIN     = 6'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_LEAD       = 4'd1,
        PH_PREFIX     = 4'd2,
        PH_DIGITS     = 4'd3,
        PH_FRAC_FIRST = 4'd4,
        PH_FRAC       = 4'd5,
        PH_EXP_SIGN   = 4'd6,
        PH_EXP_FIRST  = 4'd7,
        PH_EXP        = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ERR_OK         = 4'd0,
        ERR_PREFIX     = 4'd1,
        ERR_NO_DIGIT   = 4'd2,
        ERR_DIGIT_BIG  = 4'd3,
        ERR_TOO_MANY   = 4'd4,
        ERR_FRACTION   = 4'd5,
        ERR_EXPONENT   = 4'd6,
        ERR_BASE       = 4'd7,
        ERR_TOO_LONG   = 4'd8
    } t_err;

    typedef struct packed {
        logic [7:0] char_in;
        logic       start_scan;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic [5:0] base_found;
        logic [7:0] text_length;
        logic [9:0] consumed_count;
        logic [3:0] error_code;
    } t_out_item;

endpackage

/* design/nlr_in_stage.sv */
// ----------------------------------------------------------------------------
// nlr_in_stage
// input register: holds one character transfer until the scan logic takes it
// ----------------------------------------------------------------------------
module nlr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nlr_pkg::t_in_item i_item,
    output logic              o_stall,
    input  logic              i_take,
    output logic              o_valid,
    output nlr_pkg::t_in_item o_item
);
    import nlr_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    // room when empty or when the held item leaves this cycle
    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* design/nlr_step.sv */
// ----------------------------------------------------------------------------
// nlr_step
// per-character scan rule: next scan state and the optional result
// ----------------------------------------------------------------------------
module nlr_step #(
    parameter int MAX_DIGITS = nlr_pkg::MAX_DIGITS_DEF,
    parameter int MAX_TEXT   = nlr_pkg::MAX_TEXT_DEF,
    parameter int MAX_SCAN   = nlr_pkg::MAX_SCAN_DEF,
    localparam int DC_W      = $clog2(MAX_DIGITS + 1),
    localparam int LL_W      = $clog2(MAX_TEXT + 1),
    localparam int SC_W      = $clog2(MAX_SCAN + 1)
) (
    input  nlr_pkg::t_in_item  i_item,
    input  logic [5:0]         i_forced_base,
    input  nlr_pkg::t_phase    i_phase,
    input  logic [DC_W-1:0]    i_dc,
    input  logic [LL_W-1:0]    i_ll,
    input  logic [SC_W-1:0]    i_sc,
    input  logic [5:0]         i_base,
    output nlr_pkg::t_phase    o_phase,
    output logic [DC_W-1:0]    o_dc,
    output logic [LL_W-1:0]    o_ll,
    output logic [SC_W-1:0]    o_sc,
    output logic [5:0]         o_base,
    output logic               o_emit,
    output nlr_pkg::t_out_item o_result
);
    import nlr_pkg::*;

    logic [7:0]      c;
    t_phase          ph;
    logic [DC_W-1:0] dc;
    logic [LL_W-1:0] ll;
    logic [SC_W-1:0] sc;
    logic [5:0]      ab;
    logic            second;
    logic            tk;
    logic            tk_text;
    logic            tk_digit;
    t_phase          tk_ph;
    logic [5:0]      tk_base;
    logic            fin;
    logic            fin_ok;
    t_err            fin_err;
    logic            is_dec;
    logic            is_dig;
    logic [5:0]      dv;
    logic            text_room;
    logic            scan_room;

    always_comb begin
        c = i_item.char_in;

        // a start flag opens a new scan with the base latched now
        if (i_item.start_scan) begin
            ph = PH_LEAD;
            dc = '0;
            ll = '0;
            sc = '0;
            ab = i_forced_base;
        end else begin
            ph = i_phase;
            dc = i_dc;
            ll = i_ll;
            sc = i_sc;
            ab = i_base;
        end

        is_dec = (c >= CH_0) && (c <= CH_9);
        is_dig = 1'b1;
        dv     = '0;
        if (is_dec) begin
            dv = 6'(c - CH_0);
        end else if ((c >= CH_A) && (c <= CH_Z)) begin
            dv = 6'(c - CH_A) + 6'd10;
        end else begin
            is_dig = 1'b0;
        end

        text_room = ll < LL_W'(MAX_TEXT);
        scan_room = sc < SC_W'(MAX_SCAN);

        second   = 1'b0;
        tk       = 1'b0;
        tk_text  = 1'b0;
        tk_digit = 1'b0;
        tk_ph    = ph;
        tk_base  = ab;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        fin_err  = ERR_OK;
        o_phase  = ph;

        unique case (ph)
            PH_LEAD: begin
                if (c == CH_SPACE) begin
                    tk = 1'b1;
                end else if ((ab == '0) && (c == CH_AMP)) begin
                    tk    = 1'b1;
                    tk_ph = PH_PREFIX;
                end else begin
                    if (ab == '0) begin
                        ab = BASE_DEFAULT;
                    end
                    tk_base = ab;
                    if ((ab < BASE_MIN) || (ab > BASE_MAX)) begin
                        fin     = 1'b1;
                        fin_err = ERR_BASE;
                    end else begin
                        second = 1'b1;
                    end
                end
            end
            PH_PREFIX: begin
                tk    = 1'b1;
                tk_ph = PH_DIGITS;
                unique case (c)
                    CH_H:    tk_base = BASE_HEX;
                    CH_D:    tk_base = BASE_DEFAULT;
                    CH_O:    tk_base = BASE_OCT;
                    CH_Q:    tk_base = BASE_QUAT;
                    CH_B:    tk_base = BASE_BIN;
                    default: begin
                        tk      = 1'b0;
                        fin     = 1'b1;
                        fin_err = ERR_PREFIX;
                    end
                endcase
            end
            PH_IDLE: begin
            end
            default: begin
                second = 1'b1;
            end
        endcase

        if (second) begin
            tk_text = 1'b1;
            unique case (ph)
                PH_LEAD, PH_DIGITS: begin
                    tk_ph = PH_DIGITS;
                    if ((ab == BASE_DEFAULT) && (dc != '0) && (c == CH_E)) begin
                        tk    = 1'b1;
                        tk_ph = PH_EXP_SIGN;
                    end else if (!is_dig) begin
                        if (dc == '0) begin
                            fin     = 1'b1;
                            fin_err = ERR_NO_DIGIT;
                        end else if ((ab == BASE_DEFAULT) && (c == CH_DOT)) begin
                            tk    = 1'b1;
                            tk_ph = PH_FRAC_FIRST;
                        end else begin
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end
                    end else if (dc >= DC_W'(MAX_DIGITS)) begin
                        fin     = 1'b1;
                        fin_err = ERR_TOO_MANY;
                    end else if (dv >= ab) begin
                        fin     = 1'b1;
                        fin_err = ERR_DIGIT_BIG;
                    end else begin
                        tk       = 1'b1;
                        tk_digit = 1'b1;
                    end
                end
                PH_FRAC_FIRST: begin
                    if (!is_dec) begin
                        fin     = 1'b1;
                        fin_err = ERR_FRACTION;
                    end else begin
                        tk    = 1'b1;
                        tk_ph = PH_FRAC;
                    end
                end
                PH_FRAC: begin
                    if (is_dec || (c == CH_E)) begin
                        tk = 1'b1;
                        if (c == CH_E) begin
                            tk_ph = PH_EXP_SIGN;
                        end
                    end else begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end
                end
                PH_EXP_SIGN: begin
                    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                        tk    = 1'b1;
                        tk_ph = PH_EXP_FIRST;
                    end else if (!is_dec) begin
                        fin     = 1'b1;
                        fin_err = ERR_EXPONENT;
                    end else begin
                        tk    = 1'b1;
                        tk_ph = PH_EXP;
                    end
                end
                PH_EXP_FIRST: begin
                    if (!is_dec) begin
                        fin     = 1'b1;
                        fin_err = ERR_EXPONENT;
                    end else begin
                        tk    = 1'b1;
                        tk_ph = PH_EXP;
                    end
                end
                PH_EXP: begin
                    if (!is_dec) begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end else begin
                        tk = 1'b1;
                    end
                end
                default: begin
                    // unused phase codes fall back to idle
                    tk      = 1'b0;
                    o_phase = PH_IDLE;
                end
            endcase
        end

        o_dc   = dc;
        o_ll   = ll;
        o_sc   = sc;
        o_base = ab;

        // accept the character unless a length limit would be passed
        if (tk) begin
            if (scan_room && (text_room || !tk_text)) begin
                o_sc    = sc + SC_W'(1);
                o_ll    = tk_text  ? ll + LL_W'(1) : ll;
                o_dc    = tk_digit ? dc + DC_W'(1) : dc;
                o_base  = tk_base;
                o_phase = tk_ph;
            end else begin
                fin     = 1'b1;
                fin_err = ERR_TOO_LONG;
            end
        end else if (second && !fin && (o_phase != PH_IDLE)) begin
            o_phase = tk_ph;
        end

        o_emit = fin;
        if (fin) begin
            o_phase = PH_IDLE;
        end

        o_result.accepted       = fin_ok;
        o_result.base_found     = o_base;
        o_result.text_length    = 8'(o_ll);
        o_result.consumed_count = 10'(o_sc);
        o_result.error_code     = 4'(fin_err);
    end

endmodule

/* design/numeric_literal_recognizer_top.sv */
// ----------------------------------------------------------------------------
// numeric_literal_recognizer_top
// scans characters for numeric literals; barring a result stall, one per cycle
// ----------------------------------------------------------------------------
// usage
//   input channel carries one character per transfer plus a start flag that
//   opens a new scan; the output channel carries one result per finished scan
//   (accepted flag, base, text length, characters consumed, error code)
//   a scan ends on the first character that cannot continue the literal;
//   that character is not counted and produces the result
//   forced_base is written through i_cfg_we / i_cfg_data, by the user only
//   while idle (the block does not enforce this), and is latched when a scan starts
// datapath and throughput
//   a character is registered, then the scan rule runs combinationally
//   between the input register and the result register; one character per
//   cycle sustained unless a result must wait, set by the single state update
// stalling
//   a new character keeps flowing while a result waits; only a character that
//   would produce a second result stalls the input until the result leaves
// reset
//   synchronous active-low reset empties both registers, clears the scan state
//   and sets forced_base to zero; no result is pending afterwards
// ----------------------------------------------------------------------------
module numeric_literal_recognizer_top #(
    parameter int MAX_DIGITS = nlr_pkg::MAX_DIGITS_DEF,
    parameter int MAX_TEXT   = nlr_pkg::MAX_TEXT_DEF,
    parameter int MAX_SCAN   = nlr_pkg::MAX_SCAN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  nlr_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output nlr_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import nlr_pkg::*;

    `include "assert_macros.svh"

    localparam int DC_W = $clog2(MAX_DIGITS + 1);
    localparam int LL_W = $clog2(MAX_TEXT + 1);
    localparam int SC_W = $clog2(MAX_SCAN + 1);

    // configuration
    logic [5:0] r_forced_base;

    // scan state
    t_phase          r_phase;
    logic [DC_W-1:0] r_dc;
    logic [LL_W-1:0] r_ll;
    logic [SC_W-1:0] r_sc;
    logic [5:0]      r_base;

    t_phase          n_phase;
    logic [DC_W-1:0] n_dc;
    logic [LL_W-1:0] n_ll;
    logic [SC_W-1:0] n_sc;
    logic [5:0]      n_base;

    // input register side
    logic     w_in_valid;
    t_in_item w_in_item;
    logic     w_adv;

    // result side
    logic      w_emit;
    t_out_item w_result;
    logic      w_out_room;
    logic      r_out_valid;
    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forced_base <= '0;
        end else if (i_cfg_we) begin
            r_forced_base <= i_cfg_data;
        end
    end

    nlr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_stall (o_in_stall),
        .i_take  (w_adv),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    nlr_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_TEXT   (MAX_TEXT),
        .MAX_SCAN   (MAX_SCAN)
    ) u_step (
        .i_item        (w_in_item),
        .i_forced_base (r_forced_base),
        .i_phase       (r_phase),
        .i_dc          (r_dc),
        .i_ll          (r_ll),
        .i_sc          (r_sc),
        .i_base        (r_base),
        .o_phase       (n_phase),
        .o_dc          (n_dc),
        .o_ll          (n_ll),
        .o_sc          (n_sc),
        .o_base        (n_base),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    // result slot is free when empty or draining this cycle
    assign w_out_room = !r_out_valid || !i_out_stall;
    // a character that yields no result never waits for the output
    assign w_adv      = w_in_valid && (w_out_room || !w_emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dc    <= '0;
            r_ll    <= '0;
            r_sc    <= '0;
            r_base  <= '0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_ll    <= n_ll;
            r_sc    <= n_sc;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a finished scan always returns to idle
    `NLR_ASSERT_NEXT(a_fin_idle, w_adv && w_emit, r_phase == PH_IDLE, "scan not idle after result")
    // literal text is a part of the consumed characters
    `NLR_ASSERT_ALWAYS(a_len_le_scan, 32'(r_ll) <= 32'(r_sc), "text length exceeds consumed count")
    // consumed count never passes its limit
    `NLR_ASSERT_ALWAYS(a_scan_limit, 32'(r_sc) <= 32'(MAX_SCAN), "consumed count past limit")
    // an accepted literal carries no error
    `NLR_ASSERT_ALWAYS(a_ok_no_err, !(r_out_valid && r_out_data.accepted) || (r_out_data.error_code == 4'(ERR_OK)), "accepted result with error code")

endmodule
